### design/lpps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpps_pkg;

  // Request codes carried on the action field.
  typedef enum logic [2:0] {
    ACT_WR_START = 3'd0,
    ACT_WR_BYTE  = 3'd1,
    ACT_RD_START = 3'd2,
    ACT_RD_BYTE  = 3'd3,
    ACT_RESET    = 3'd4
  } action_e;

  // Sequencer states around the single-port pool memory.
  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_HDR,
    S_RD_LO,
    S_RD_HI,
    S_RD_BYTE
  } state_e;

  // Each packet sits behind a two-byte little-endian length header.
  localparam int unsigned HDR_BYTES = 2;

  // Width of the packet length and copy counters.
  localparam int unsigned LEN_W = 16;

endpackage

`default_nettype wire

### design/length_prefixed_packet_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Ports
// request   in         start_i && !busy_o      action_i, packet_length_i, data_in_i,
//                                              max_copy_i
// result    out        done_o (one cycle)      accepted_o, read_length_o, is_empty_o,
//                                              data_out_o, data_valid_o, last_byte_o
//
// One result per request on done_o. Direct from idle: write byte, reset, unused codes, a
// rejected write start, read start when empty, read byte past the copy. An accepted
// write start does two header writes (result during the second), read byte one read,
// read start two header reads. busy_o is high while a request holds the port.
// Reset clears the indices and counters only; the pool memory is not cleared.
// The receiver cannot stall: done_o is shown for one cycle and must be taken.

module length_prefixed_packet_store #(
  parameter int unsigned POOL_BYTES = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [2:0]                action_i,
  input  wire logic [lpps_pkg::LEN_W-1:0] packet_length_i,
  input  wire logic [7:0]                data_in_i,
  input  wire logic [lpps_pkg::LEN_W-1:0] max_copy_i,
  output logic                           done_o,
  output logic                           accepted_o,
  output logic [lpps_pkg::LEN_W-1:0]     read_length_o,
  output logic                           is_empty_o,
  output logic [7:0]                     data_out_o,
  output logic                           data_valid_o,
  output logic                           last_byte_o
);

  import lpps_pkg::*;

  // Indices run up to POOL_BYTES itself; addresses only below it.
  localparam int IDX_W = $clog2(POOL_BYTES + 1);
  localparam int AW    = $clog2(POOL_BYTES);
  localparam int CW    = (IDX_W > LEN_W + 1) ? IDX_W : LEN_W + 1;
  localparam int SW    = CW + 1;
  localparam logic [IDX_W-1:0] POOL_IDX = IDX_W'(POOL_BYTES);

  state_e state_q, state_d;

  // Index and counter state.
  logic [IDX_W-1:0] cwi_q, cwi_d;
  logic [IDX_W-1:0] wc_q, wc_d;
  logic [LEN_W-1:0] wbl_q, wbl_d;
  logic [IDX_W-1:0] ri_q, ri_d;
  logic [IDX_W-1:0] rc_q, rc_d;
  logic [LEN_W-1:0] copy_q, copy_d;

  // Values held across the steps of one request.
  logic [IDX_W-1:0] hdr_addr_q, hdr_addr_d;
  logic [7:0]       hdr_byte_q, hdr_byte_d;
  logic [LEN_W-1:0] max_q, max_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic             last_q, last_d;

  // Result registers.
  logic             done_q, done_d;
  logic             accepted_q, accepted_d;
  logic [LEN_W-1:0] rlen_q, rlen_d;
  logic             empty_q, empty_d;
  logic [7:0]       dout_q, dout_d;
  logic             dvalid_q, dvalid_d;
  logic             dlast_q, dlast_d;

  // Memory port.
  logic [7:0]       pool_mem [POOL_BYTES];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [7:0]       mem_wdata;
  logic             mem_ok;
  logic [7:0]       rdata_q;
  logic             rd_ok_q;
  logic [7:0]       rd_byte;

  // Datapath helpers.
  logic             empty;
  logic [IDX_W-1:0] base;
  logic [CW-1:0]    free_space, need_space;
  logic             fits;
  logic [LEN_W-1:0] hdr_len;
  logic [SW-1:0]    ri_next;
  logic [LEN_W-1:0] copy_len;

  assign empty      = (ri_q == cwi_q);
  assign base       = empty ? '0 : cwi_q;
  assign free_space = CW'(POOL_BYTES) - CW'(base);
  assign need_space = CW'(packet_length_i) + CW'(HDR_BYTES);
  assign fits       = (free_space >= need_space);

  assign rd_byte  = rd_ok_q ? rdata_q : 8'h00;
  assign hdr_len  = {rd_byte, len_lo_q};
  assign ri_next  = SW'(ri_q) + SW'(HDR_BYTES) + SW'(hdr_len);
  assign copy_len = (max_q < hdr_len) ? max_q : hdr_len;

  assign mem_ok = (mem_addr < POOL_IDX);

  // Single-port pool memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_ok) begin
      pool_mem[mem_addr[AW-1:0]] <= mem_wdata;
    end
    if (mem_re && mem_ok) begin
      rdata_q <= pool_mem[mem_addr[AW-1:0]];
    end
    if (mem_re) begin
      rd_ok_q <= mem_ok;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cwi_q   <= '0;
      wc_q    <= '0;
      wbl_q   <= '0;
      ri_q    <= '0;
      rc_q    <= '0;
      copy_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cwi_q   <= cwi_d;
      wc_q    <= wc_d;
      wbl_q   <= wbl_d;
      ri_q    <= ri_d;
      rc_q    <= rc_d;
      copy_q  <= copy_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hdr_addr_q <= hdr_addr_d;
    hdr_byte_q <= hdr_byte_d;
    max_q      <= max_d;
    len_lo_q   <= len_lo_d;
    last_q     <= last_d;
    accepted_q <= accepted_d;
    rlen_q     <= rlen_d;
    empty_q    <= empty_d;
    dout_q     <= dout_d;
    dvalid_q   <= dvalid_d;
    dlast_q    <= dlast_d;
  end

  // Sequencer: next state, index updates and memory port control.
  always_comb begin
    state_d    = state_q;
    cwi_d      = cwi_q;
    wc_d       = wc_q;
    wbl_d      = wbl_q;
    ri_d       = ri_q;
    rc_d       = rc_q;
    copy_d     = copy_q;
    hdr_addr_d = hdr_addr_q;
    hdr_byte_d = hdr_byte_q;
    max_d      = max_q;
    len_lo_d   = len_lo_q;
    last_d     = last_q;
    done_d     = 1'b0;
    accepted_d = 1'b0;
    rlen_d     = '0;
    empty_d    = empty;
    dout_d     = 8'h00;
    dvalid_d   = 1'b0;
    dlast_d    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = hdr_addr_q;
    mem_wdata  = hdr_byte_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (action_i)
            ACT_WR_START: begin
              // An empty store restarts at the bottom before the space check.
              done_d = 1'b1;
              wbl_d  = '0;
              if (empty) begin
                ri_d  = '0;
                cwi_d = '0;
              end
              if (fits) begin
                accepted_d = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = base;
                mem_wdata  = packet_length_i[7:0];
                hdr_addr_d = base + IDX_W'(1);
                hdr_byte_d = packet_length_i[15:8];
                wc_d       = base + IDX_W'(HDR_BYTES);
                wbl_d      = packet_length_i;
                if (packet_length_i == '0) begin
                  cwi_d = base + IDX_W'(HDR_BYTES);
                end
                state_d = S_WR_HDR;
              end
            end
            ACT_WR_BYTE: begin
              // The write index commits with the last byte of the packet.
              done_d = 1'b1;
              if (wbl_q != '0) begin
                mem_we    = 1'b1;
                mem_addr  = wc_q;
                mem_wdata = data_in_i;
                wc_d      = wc_q + IDX_W'(1);
                wbl_d     = wbl_q - LEN_W'(1);
                if (wbl_q == LEN_W'(1)) begin
                  cwi_d = wc_q + IDX_W'(1);
                end
              end
            end
            ACT_RD_START: begin
              copy_d = '0;
              if (!empty) begin
                mem_re   = 1'b1;
                mem_addr = ri_q;
                max_d    = max_copy_i;
                state_d  = S_RD_LO;
              end else begin
                done_d = 1'b1;
              end
            end
            ACT_RD_BYTE: begin
              if (copy_q != '0) begin
                mem_re   = 1'b1;
                mem_addr = rc_q;
                last_d   = (copy_q == LEN_W'(1));
                rc_d     = rc_q + IDX_W'(1);
                copy_d   = copy_q - LEN_W'(1);
                state_d  = S_RD_BYTE;
              end else begin
                done_d = 1'b1;
              end
            end
            ACT_RESET: begin
              done_d = 1'b1;
              cwi_d  = '0;
              ri_d   = '0;
              wc_d   = '0;
              wbl_d  = '0;
              rc_d   = '0;
              copy_d = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_WR_HDR: begin
        // Second header byte, high half of the length.
        mem_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_RD_LO: begin
        // Low header byte is back; fetch the high one.
        mem_re   = 1'b1;
        mem_addr = ri_q + IDX_W'(1);
        len_lo_d = rd_byte;
        state_d  = S_RD_HI;
      end
      S_RD_HI: begin
        // Full length known: open the copy and step past the whole packet.
        rc_d    = ri_q + IDX_W'(HDR_BYTES);
        copy_d  = copy_len;
        ri_d    = ri_next[IDX_W-1:0];
        done_d  = 1'b1;
        rlen_d  = hdr_len;
        empty_d = 1'b0;
        state_d = S_IDLE;
      end
      S_RD_BYTE: begin
        done_d   = 1'b1;
        dout_d   = rd_byte;
        dvalid_d = 1'b1;
        dlast_d  = last_q;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign accepted_o    = accepted_q;
  assign read_length_o = rlen_q;
  assign is_empty_o    = empty_q;
  assign data_out_o    = dout_q;
  assign data_valid_o  = dvalid_q;
  assign last_byte_o   = dlast_q;

  // The read index never passes the committed write index.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ri_q <= cwi_q)
    else $error("read index beyond committed write index");

  // The committed write index stays inside the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cwi_q <= POOL_IDX)
    else $error("committed write index beyond pool");

  // A header fetch ends in a result that reports a stored packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD_HI |=> done_o && !is_empty_o && !busy_o)
    else $error("header fetch did not deliver its result");

  // A final-byte flag comes only with a delivered byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> data_valid_o && done_o)
    else $error("last byte flag without a valid byte");

endmodule

`default_nettype wire
